/* hw/rtl/lzd_pkg.sv */
`default_nettype none

package lzd_pkg;

  // compressed stream format
  localparam int HDR_BYTES  = 4;
  localparam int OFS_W      = 12;
  localparam int DIST_W     = OFS_W + 1;
  localparam int TOKLEN_W   = 5;
  localparam int MIN_MATCH  = 3;
  localparam int FLAG_COUNT = 8;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG,
    PH_LITERAL,
    PH_MATCH_HI,
    PH_MATCH_LO,
    PH_DONE
  } lzd_phase_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LIT,
    CMD_MATCH
  } lzd_kind_t;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_RAM,
    SRC_PREV
  } lzd_src_t;

  // one work command from the parser to the copy engine
  typedef struct packed {
    lzd_kind_t             kind;
    logic [7:0]            data;
    logic [DIST_W-1:0]     match_dist;
    logic [TOKLEN_W-1:0]   count;
    logic                  done;
  } lzd_cmd_t;

  // one result byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } lzd_res_t;

endpackage

`default_nettype wire

/* hw/rtl/lzd_fifo.sv */
`default_nettype none

module lzd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             din,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  dout,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lzd_ram.sv */
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/lzd_front.sv */
`default_nettype none

module lzd_front
  import lzd_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_first,
  output logic            cmd_push,
  output lzd_cmd_t        cmd
);

  localparam int RW = LENGTH_BITS;

  lzd_phase_t          phase_r, phase_nxt;
  logic [1:0]          hdr_idx_r, hdr_idx_nxt;
  logic [15:0]         hdr_lo_r, hdr_lo_nxt;
  logic [RW-1:0]       remaining_r, remaining_nxt;
  logic [7:0]          flag_shift_r, flag_shift_nxt;
  logic [3:0]          flags_left_r, flags_left_nxt;
  logic [7:0]          match_high_r, match_high_nxt;

  logic                accept;
  logic [23:0]         hdr_len;
  logic [TOKLEN_W-1:0] tok_len;
  logic [DIST_W-1:0]   tok_dist;
  logic [23:0]         rem_ext;
  logic                rem_short;
  logic [TOKLEN_W-1:0] emit_n;
  logic [7:0]          tok_shift;
  logic [3:0]          tok_left;
  lzd_phase_t          tok_phase;

  assign accept    = in_push && !in_full;
  assign hdr_len   = {in_byte, hdr_lo_r};
  assign tok_len   = TOKLEN_W'(match_high_r[7:4]) + TOKLEN_W'(MIN_MATCH);
  assign tok_dist  = DIST_W'({match_high_r[3:0], in_byte}) + DIST_W'(1);
  assign rem_ext   = 24'(remaining_r);
  assign rem_short = (rem_ext <= 24'(tok_len));
  assign emit_n    = rem_short ? TOKLEN_W'(rem_ext) : tok_len;

  // advance to the next token of the current flag byte
  assign tok_shift = {flag_shift_r[6:0], 1'b0};
  assign tok_left  = flags_left_r - 4'd1;
  assign tok_phase = (tok_left == 4'd0) ? PH_FLAG :
                     (tok_shift[7] ? PH_MATCH_HI : PH_LITERAL);

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    hdr_lo_nxt     = hdr_lo_r;
    remaining_nxt  = remaining_r;
    flag_shift_nxt = flag_shift_r;
    flags_left_nxt = flags_left_r;
    match_high_nxt = match_high_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.kind       = CMD_CLEAR;
    if (accept) begin
      if (in_first) begin
        cmd_push       = 1'b1;
        cmd.kind       = CMD_CLEAR;
        phase_nxt      = PH_HEADER;
        hdr_idx_nxt    = 2'd1;
        remaining_nxt  = '0;
        flag_shift_nxt = '0;
        flags_left_nxt = '0;
        match_high_nxt = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (hdr_idx_r == 2'd1) begin
              hdr_lo_nxt[7:0] = in_byte;
            end else begin
              hdr_lo_nxt[15:8] = in_byte;
            end
            if (hdr_idx_r == 2'(HDR_BYTES - 1)) begin
              hdr_idx_nxt   = '0;
              remaining_nxt = hdr_len[RW-1:0];
              phase_nxt     = (hdr_len[RW-1:0] != '0) ? PH_FLAG : PH_DONE;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 2'd1;
            end
          end
          PH_FLAG: begin
            flag_shift_nxt = in_byte;
            flags_left_nxt = 4'(FLAG_COUNT);
            phase_nxt      = in_byte[7] ? PH_MATCH_HI : PH_LITERAL;
          end
          PH_LITERAL: begin
            cmd_push      = 1'b1;
            cmd.kind      = CMD_LIT;
            cmd.data      = in_byte;
            cmd.count     = TOKLEN_W'(1);
            cmd.done      = (remaining_r == RW'(1));
            remaining_nxt = remaining_r - RW'(1);
            if (remaining_r == RW'(1)) begin
              phase_nxt = PH_DONE;
            end else begin
              flag_shift_nxt = tok_shift;
              flags_left_nxt = tok_left;
              phase_nxt      = tok_phase;
            end
          end
          PH_MATCH_HI: begin
            match_high_nxt = in_byte;
            phase_nxt      = PH_MATCH_LO;
          end
          PH_MATCH_LO: begin
            cmd_push       = 1'b1;
            cmd.kind       = CMD_MATCH;
            cmd.match_dist = tok_dist;
            cmd.count      = emit_n;
            cmd.done       = rem_short;
            remaining_nxt  = remaining_r - RW'(emit_n);
            if (rem_short) begin
              phase_nxt = PH_DONE;
            end else begin
              flag_shift_nxt = tok_shift;
              flags_left_nxt = tok_left;
              phase_nxt      = tok_phase;
            end
          end
          default: begin
            // idle or finished stream: byte dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hdr_idx_r    <= '0;
      remaining_r  <= '0;
      flag_shift_r <= '0;
      flags_left_r <= '0;
      match_high_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      remaining_r  <= remaining_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      match_high_r <= match_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_lo_r <= hdr_lo_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !in_full)
    else $error("command pushed into a full queue");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (remaining_r == '0))
    else $error("stream finished with bytes still owed");

endmodule

`default_nettype wire

/* hw/rtl/lzd_back.sv */
`default_nettype none

module lzd_back
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096,
  parameter int OUT_DEPTH_P  = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  input  wire lzd_cmd_t                         cmd,
  output logic                                  cmd_pop,
  input  wire logic [$clog2(OUT_DEPTH_P+1)-1:0] out_cnt,
  output logic                                  res_push,
  output lzd_res_t                              res
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int OCW   = $clog2(OUT_DEPTH_P + 1);

  // issue side
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [TOKLEN_W-1:0] cnt_r, cnt_nxt;
  logic                room, clr, issue, last_b, far;
  lzd_src_t            src;
  logic [7:0]          src_data;
  logic [DIST_W-1:0]   back_pos;
  logic [AW-1:0]       rd_addr;

  // write side
  logic                s2_valid_r;
  lzd_src_t            s2_src_r;
  logic [7:0]          s2_data_r;
  logic [AW-1:0]       s2_addr_r;
  logic                s2_last_r, s2_done_r;
  logic [7:0]          prev_r;
  logic [7:0]          ram_rdata;
  logic [7:0]          wr_byte;

  assign room   = ((OCW+1)'(out_cnt) + (OCW+1)'(s2_valid_r)) < (OCW+1)'(OUT_DEPTH_P);
  assign clr    = cmd_valid && (cmd.kind == CMD_CLEAR);
  assign issue  = cmd_valid && (cmd.kind != CMD_CLEAR) && room;
  assign last_b = (cnt_r == (cmd.count - TOKLEN_W'(1)));
  assign far    = (CNT_W+1)'(cmd.match_dist) > (CNT_W+1)'(fill_r);
  assign cmd_pop = clr || (issue && last_b);

  assign back_pos = DIST_W'(wp_r) - cmd.match_dist;
  assign rd_addr  = back_pos[AW-1:0];

  always_comb begin
    src      = SRC_REG;
    src_data = cmd.data;
    case (cmd.kind)
      CMD_MATCH: begin
        if (far) begin
          // before the start of the stream
          src      = SRC_REG;
          src_data = '0;
        end else if (cmd.match_dist == DIST_W'(1)) begin
          // byte just written, not yet readable from the window
          src = SRC_PREV;
        end else begin
          src = SRC_RAM;
        end
      end
      default: begin
        src      = SRC_REG;
        src_data = cmd.data;
      end
    endcase
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    if (clr) begin
      wp_nxt   = '0;
      fill_nxt = '0;
      cnt_nxt  = '0;
    end else if (issue) begin
      wp_nxt  = wp_r + AW'(1);
      cnt_nxt = last_b ? '0 : cnt_r + TOKLEN_W'(1);
      if (fill_r != CNT_W'(WINDOW_DEPTH)) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      fill_r     <= '0;
      cnt_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      s2_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_src_r  <= src;
      s2_data_r <= src_data;
      s2_addr_r <= wp_r;
      s2_last_r <= last_b;
      s2_done_r <= last_b && cmd.done;
    end
    if (s2_valid_r) begin
      prev_r <= wr_byte;
    end
  end

  always_comb begin
    case (s2_src_r)
      SRC_RAM:  wr_byte = ram_rdata;
      SRC_PREV: wr_byte = prev_r;
      default:  wr_byte = s2_data_r;
    endcase
  end

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (s2_valid_r),
    .waddr (s2_addr_r),
    .wdata (wr_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign res_push = s2_valid_r;

  always_comb begin
    res      = '0;
    res.data = wr_byte;
    res.last = s2_last_r;
    res.done = s2_done_r;
  end

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> ((OCW+1)'(out_cnt) < (OCW+1)'(OUT_DEPTH_P)))
    else $error("result pushed into a full output queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill count overran");

  a_clear_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (wp_r == '0) && (fill_r == '0))
    else $error("new stream did not rewind the window");

endmodule

`default_nettype wire

/* hw/rtl/lz77_stream_decompressor_top.sv */
`default_nettype none

// lz77 stream decompressor, 4 KiB history window, lz10 token format
//
// input channel: one compressed byte per transfer (in_push / in_full),
// in_first marks the type byte of a new stream and restarts the parser
// and window; the next three bytes give the output length, low byte first
// result channel: one decompressed byte per transfer (out_empty / out_pop);
// out_last flags the final byte produced by one input byte, out_stream_done
// flags the byte that completes the declared length
//
// a parser takes one input byte per cycle while the command queue has room
// and turns tokens into commands in a 4-entry queue; a copy engine drains
// them through the history ram into a 4-entry result queue, at one output
// byte per cycle while a slot is free; header, flag and match-high bytes
// cost the copy engine nothing, a literal writes one byte and a match one
// byte per cycle, bounded by the single write port of the window ram
// result path: command queue, write-stage registers, then the result queue
// reset: parser idle, queues empty, window counted as empty (no sweep)
// receiver stall: the result queue fills, the copy engine holds, then the
// command queue fills and in_full rises; nothing is dropped

module lz77_stream_decompressor_top
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096,
  parameter int LENGTH_BITS  = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_first,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_stream_done
);

  localparam int CMD_W = $bits(lzd_cmd_t);
  localparam int RES_W = $bits(lzd_res_t);

  // parser to copy engine
  logic     cmd_push, cmd_pop, cmd_empty;
  lzd_cmd_t cmd_in, cmd_head;

  // copy engine to result queue
  logic                             res_push;
  lzd_res_t                         res_in, res_head;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_cnt;

  lzd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_byte  (in_byte),
    .in_first (in_first),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // command queue, its full flag is the input back-pressure
  lzd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty),
    .count ()
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUT_DEPTH_P  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_cnt   (out_cnt),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue, the copy engine only issues a byte when a slot is free
  lzd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty),
    .count (out_cnt)
  );

  assign out_byte        = res_head.data;
  assign out_last        = res_head.last;
  assign out_stream_done = res_head.done;

endmodule

`default_nettype wire
